// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHECK_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("check failed: property does not hold");

// condition in one cycle forces an expression in the next
`define CHECK_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("check failed: next-cycle expectation missed");

`endif

// File: rtl/hpq_pkg.sv
package hpq_pkg;

    // operation codes on the input word
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    // status codes on the result word
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // one heap entry
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] data;
    } entry_t;

    // entry travelling along the chain of level cells
    typedef struct packed {
        logic   valid;
        entry_t ent;
    } tok_t;

    // true when key a belongs above key b in the configured order
    function automatic logic better(input logic mn, input logic [31:0] a,
                                    input logic [31:0] b);
        return mn ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
    endfunction

endpackage

// File: rtl/hpq_cell.sv
module hpq_cell
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int LEVEL    = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              min_order,
    input  logic [$clog2(CAPACITY+1)-1:0]     cnt,
    // controller read by heap index
    input  logic                              rd_en,
    input  logic [$clog2(CAPACITY)-1:0]       rd_idx,
    output entry_t                            rd_ent,
    // insert start by heap index
    input  tok_t                              ins_tok,
    input  logic [$clog2(CAPACITY)-1:0]       ins_idx,
    // tokens from and to the neighbors
    input  tok_t                              dn_in,
    input  logic [$clog2(CAPACITY)-1:0]       dn_off_in,
    output tok_t                              dn_out,
    output logic [$clog2(CAPACITY)-1:0]       dn_off_out,
    input  tok_t                              up_in,
    input  logic [$clog2(CAPACITY)-1:0]       up_off_in,
    output tok_t                              up_out,
    output logic [$clog2(CAPACITY)-1:0]       up_off_out,
    // reads of the neighbor levels
    output logic                              kid_rq,
    output logic [$clog2(CAPACITY)-1:0]       kid_row,
    input  entry_t [1:0]                      kid_pair,
    output logic                              par_rq,
    output logic [$clog2(CAPACITY)-1:0]       par_off,
    input  entry_t [1:0]                      par_pair,
    // reads of this level by the neighbors
    input  logic                              above_rq,
    input  logic [$clog2(CAPACITY)-1:0]       above_row,
    input  logic                              below_rq,
    input  logic [$clog2(CAPACITY)-1:0]       below_off,
    output entry_t [1:0]                      pair_out,
    output logic                              done
);

    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int NLEV     = CW;
    localparam int XW       = CW + 1;
    localparam int BASE     = (1 << LEVEL) - 1;
    localparam int BASE_KID = (1 << (LEVEL + 1)) - 1;
    localparam int SPAN     = 1 << LEVEL;
    localparam int ENTRIES  = (SPAN < CAPACITY - BASE) ? SPAN : CAPACITY - BASE;
    localparam int ROWS     = (ENTRIES + 1) / 2;
    localparam int RAW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam bit HAS_KIDS = (LEVEL < NLEV - 1);
    localparam bit HAS_PAR  = (LEVEL > 0);

    // storage of this level, sibling pairs side by side
    entry_t [1:0] mem_reg [ROWS];

    logic         act_dn_reg, act_dn_next;
    logic         act_up_reg, act_up_next;
    entry_t       x_reg, x_next;
    logic [AW-1:0] o_reg, o_next;

    logic [XW-1:0] ins_p1, rd_p1, lidx;
    logic          ins_hit, rd_hit;
    logic [AW-1:0] ins_off, rd_off, sel_hi, wr_hi;
    logic [RAW-1:0] rd_row, wr_row;
    logic          has_l, has_r, pick_r, dn_move, up_move;
    entry_t        pick, par_ent, wr_ent;
    logic          wr_en;

    // index decode: which level a heap index falls in
    always_comb
    begin
        ins_p1  = XW'(ins_idx) + XW'(1);
        rd_p1   = XW'(rd_idx) + XW'(1);
        ins_hit = ins_tok.valid && ((ins_p1 >> LEVEL) == XW'(1));
        rd_hit  = rd_en && ((rd_p1 >> LEVEL) == XW'(1));
        ins_off = AW'(XW'(ins_idx) - XW'(BASE));
        rd_off  = AW'(XW'(rd_idx) - XW'(BASE));
    end

    // one read row, shared by controller and neighbors
    always_comb
    begin
        priority if (rd_hit)
            sel_hi = rd_off >> 1;
        else if (above_rq)
            sel_hi = above_row;
        else if (below_rq)
            sel_hi = below_off >> 1;
        else
            sel_hi = '0;
        rd_row   = sel_hi[RAW-1:0];
        pair_out = mem_reg[rd_row];
        rd_ent   = rd_hit ? pair_out[rd_off[0]] : '0;
    end

    // sift step of the entry held in this level
    always_comb
    begin
        lidx    = XW'(BASE_KID) + (XW'(o_reg) << 1);
        has_l   = HAS_KIDS && (lidx < XW'(cnt));
        has_r   = HAS_KIDS && ((lidx + XW'(1)) < XW'(cnt));
        pick_r  = has_r && better(min_order, kid_pair[1].key, kid_pair[0].key);
        pick    = pick_r ? kid_pair[1] : kid_pair[0];
        dn_move = act_dn_reg && has_l && better(min_order, pick.key, x_reg.key);

        par_off = o_reg >> 1;
        par_ent = par_pair[par_off[0]];
        up_move = act_up_reg && HAS_PAR && better(min_order, x_reg.key, par_ent.key);

        wr_en   = act_dn_reg || act_up_reg;
        if (dn_move)
            wr_ent = pick;
        else if (up_move)
            wr_ent = par_ent;
        else
            wr_ent = x_reg;
        wr_hi   = o_reg >> 1;
        wr_row  = wr_hi[RAW-1:0];
        done    = (act_dn_reg && !dn_move) || (act_up_reg && !up_move);

        kid_rq  = act_dn_reg;
        kid_row = o_reg;
        par_rq  = act_up_reg;

        dn_out.valid = dn_move;
        dn_out.ent   = x_reg;
        dn_off_out   = (o_reg << 1) | AW'(pick_r);
        up_out.valid = up_move;
        up_out.ent   = x_reg;
        up_off_out   = par_off;
    end

    // token arrival and departure
    always_comb
    begin
        act_dn_next = 1'b0;
        act_up_next = 1'b0;
        x_next      = x_reg;
        o_next      = o_reg;
        if (dn_in.valid)
        begin
            act_dn_next = 1'b1;
            x_next      = dn_in.ent;
            o_next      = dn_off_in;
        end
        if (up_in.valid)
        begin
            act_up_next = 1'b1;
            x_next      = up_in.ent;
            o_next      = up_off_in;
        end
        if (ins_hit)
        begin
            act_up_next = 1'b1;
            x_next      = ins_tok.ent;
            o_next      = ins_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_dn_reg <= 1'b0;
            act_up_reg <= 1'b0;
        end
        else
        begin
            act_dn_reg <= act_dn_next;
            act_up_reg <= act_up_next;
        end
    end

    // carried entry and storage
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        o_reg <= o_next;
        if (wr_en)
            mem_reg[wr_row][o_reg[0]] <= wr_ent;
    end

endmodule

// File: rtl/hpq_ctrl.sv
module hpq_ctrl
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic signed [31:0]                key,
    input  logic [31:0]                       data,
    input  logic [$clog2(CAPACITY)-1:0]       index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic signed [31:0]                out_key,
    output logic [31:0]                       out_data,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
    // chain side
    output logic                              min_order,
    output logic [$clog2(CAPACITY+1)-1:0]     cnt,
    output logic                              rd_en,
    output logic [$clog2(CAPACITY)-1:0]       rd_idx,
    input  entry_t                            rd_ent,
    output tok_t                              ins_tok,
    output logic [$clog2(CAPACITY)-1:0]       ins_idx,
    output tok_t                              dn_start,
    input  logic                              walk_done
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXT_LAST,
        S_WALK,
        S_HOLD
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          min_order_reg, min_order_next;
    status_t       res_status_reg, res_status_next;
    logic [31:0]   res_key_reg, res_key_next;
    logic [31:0]   res_data_reg, res_data_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [31:0]   out_key_reg, out_key_next;
    logic [31:0]   out_data_reg, out_data_next;
    logic [CW-1:0] out_count_reg, out_count_next;
    logic          accept;
    op_t           op;

    always_comb
    begin
        op              = op_t'(opcode);
        in_ready        = (state_reg == S_IDLE);
        accept          = in_valid && in_ready;
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        min_order_next  = cfg_we ? cfg_wdata : min_order_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;

        // controller reads: top or requested entry, then the last entry
        rd_en  = (state_reg == S_IDLE) || (state_reg == S_EXT_LAST);
        rd_idx = (state_reg == S_EXT_LAST) ? cnt_reg[AW-1:0]
               : ((op == OP_EXTRACT) ? '0 : index);

        ins_tok      = '0;
        ins_tok.ent  = '{key: key, data: data};
        ins_idx      = cnt_reg[AW-1:0];
        dn_start     = '0;
        dn_start.ent = rd_ent;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_key_next    = '0;
                    res_data_next   = '0;
                    state_next      = S_HOLD;
                    unique case (op)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                                res_status_next = ST_FULL;
                            else
                            begin
                                ins_tok.valid = 1'b1;
                                cnt_next      = cnt_reg + CW'(1);
                                state_next    = S_WALK;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            if (cnt_reg == '0)
                                res_status_next = ST_EMPTY;
                            else
                            begin
                                res_key_next  = rd_ent.key;
                                res_data_next = rd_ent.data;
                                cnt_next      = cnt_reg - CW'(1);
                                state_next    = S_EXT_LAST;
                            end
                        end
                        OP_CLEAR:
                            cnt_next = '0;
                        OP_READ:
                        begin
                            if (CW'(index) >= cnt_reg)
                                res_status_next = ST_RANGE;
                            else
                            begin
                                res_key_next  = rd_ent.key;
                                res_data_next = rd_ent.data;
                            end
                        end
                    endcase
                end
            end
            S_EXT_LAST:
            begin
                // last entry moves into the root hole and sifts down
                if (cnt_reg == '0)
                    state_next = S_HOLD;
                else
                begin
                    dn_start.valid = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_key_next    = res_key_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = cnt_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            min_order_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_key_reg    <= '0;
            res_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_key_reg    <= '0;
            out_data_reg   <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            min_order_reg  <= min_order_next;
            res_status_reg <= res_status_next;
            res_key_reg    <= res_key_next;
            res_data_reg   <= res_data_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_key_reg    <= out_key_next;
            out_data_reg   <= out_data_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign min_order   = min_order_reg;
    assign cnt         = cnt_reg;
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign out_key     = out_key_reg;
    assign out_data    = out_data_reg;
    assign entry_count = out_count_reg;

endmodule

// File: rtl/binary_heap_priority_queue.sv
// channel   handshake               word
// cfg       cfg_we                  cfg_wdata (min_order)
// in        in_valid / in_ready     opcode, key, data, index
// out       out_valid / out_ready   status, out_key, out_data, entry_count
//
// one operation at a time; one heap level per cell, one level step per cycle
// accept to out_valid: read, clear, full insert, empty extract go straight to the hold state
// insert climbs in the walk state; extract reads the last entry, then sifts it down, unless it empties the heap
// the next word can be taken in the same cycle that out_valid rises
// rst_n clears the count and order; stored entries are not cleared
// a result waiting on out_ready does not block the next accept
`include "assert_macros.svh"

module binary_heap_priority_queue
    import hpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        opcode,
    input  logic signed [31:0]                key,
    input  logic [31:0]                       data,
    input  logic [$clog2(CAPACITY)-1:0]       index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic signed [31:0]                out_key,
    output logic [31:0]                       out_data,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NLEV = CW;

    logic          min_order;
    logic [CW-1:0] cnt;
    logic          rd_en;
    logic [AW-1:0] rd_idx;
    entry_t        rd_ent;
    tok_t          ins_tok;
    logic [AW-1:0] ins_idx;
    tok_t          dn_start;
    logic          walk_done;

    tok_t          dn_tok [NLEV];
    logic [AW-1:0] dn_off [NLEV];
    tok_t          up_tok [NLEV];
    logic [AW-1:0] up_off [NLEV];
    logic [AW-1:0] kid_row [NLEV];
    logic [AW-1:0] par_off [NLEV];
    entry_t [1:0]  pair [NLEV];
    entry_t        rd_ent_lvl [NLEV];
    logic [NLEV-1:0] kid_rq_vec, par_rq_vec, done_vec;

    hpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .data        (data),
        .index       (index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_key     (out_key),
        .out_data    (out_data),
        .entry_count (entry_count),
        .min_order   (min_order),
        .cnt         (cnt),
        .rd_en       (rd_en),
        .rd_idx      (rd_idx),
        .rd_ent      (rd_ent),
        .ins_tok     (ins_tok),
        .ins_idx     (ins_idx),
        .dn_start    (dn_start),
        .walk_done   (walk_done)
    );

    // chain of level cells, root first
    for (genvar L = 0; L < NLEV; L++)
    begin : g_lvl
        tok_t          dn_in, up_in;
        logic [AW-1:0] dn_off_in, up_off_in, above_row, below_off;
        entry_t [1:0]  kid_pair, par_pair;
        logic          above_rq, below_rq;

        if (L == 0)
        begin : g_root
            assign dn_in     = dn_start;
            assign dn_off_in = '0;
            assign par_pair  = '0;
            assign above_rq  = 1'b0;
            assign above_row = '0;
        end
        else
        begin : g_inner
            assign dn_in     = dn_tok[L-1];
            assign dn_off_in = dn_off[L-1];
            assign par_pair  = pair[L-1];
            assign above_rq  = kid_rq_vec[L-1];
            assign above_row = kid_row[L-1];
        end

        if (L == NLEV - 1)
        begin : g_leaf
            assign up_in     = '0;
            assign up_off_in = '0;
            assign kid_pair  = '0;
            assign below_rq  = 1'b0;
            assign below_off = '0;
        end
        else
        begin : g_upper
            assign up_in     = up_tok[L+1];
            assign up_off_in = up_off[L+1];
            assign kid_pair  = pair[L+1];
            assign below_rq  = par_rq_vec[L+1];
            assign below_off = par_off[L+1];
        end

        hpq_cell #(
            .CAPACITY (CAPACITY),
            .LEVEL    (L)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .min_order  (min_order),
            .cnt        (cnt),
            .rd_en      (rd_en),
            .rd_idx     (rd_idx),
            .rd_ent     (rd_ent_lvl[L]),
            .ins_tok    (ins_tok),
            .ins_idx    (ins_idx),
            .dn_in      (dn_in),
            .dn_off_in  (dn_off_in),
            .dn_out     (dn_tok[L]),
            .dn_off_out (dn_off[L]),
            .up_in      (up_in),
            .up_off_in  (up_off_in),
            .up_out     (up_tok[L]),
            .up_off_out (up_off[L]),
            .kid_rq     (kid_rq_vec[L]),
            .kid_row    (kid_row[L]),
            .kid_pair   (kid_pair),
            .par_rq     (par_rq_vec[L]),
            .par_off    (par_off[L]),
            .par_pair   (par_pair),
            .above_rq   (above_rq),
            .above_row  (above_row),
            .below_rq   (below_rq),
            .below_off  (below_off),
            .pair_out   (pair[L]),
            .done       (done_vec[L])
        );
    end

    // only the addressed level drives its read word
    always_comb
    begin
        rd_ent = '0;
        for (int l = 0; l < NLEV; l++)
            rd_ent = rd_ent | rd_ent_lvl[l];
    end

    assign walk_done = |done_vec;

    // at most one level finishes a walk in any cycle
    `CHECK_HOLDS(a_one_finisher, clk, rst_n, $onehot0(done_vec))
    // a walk ends only while no word can be taken
    `CHECK_HOLDS(a_busy_on_done, clk, rst_n, walk_done |-> !in_ready)
    // controller reads never overlap a neighbor read of the chain
    `CHECK_HOLDS(a_read_quiet, clk, rst_n, rd_en |-> ((kid_rq_vec | par_rq_vec) == '0))
    // a started insert holds the input off while it climbs
    `CHECK_NEXT(a_insert_blocks, clk, rst_n, ins_tok.valid, !in_ready)

endmodule
